// ----- sv/assert_macros.svh -----
// Assertion macros shared by the merge block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under reset
`define KWM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication under reset
`define KWM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- sv/kwm_pkg.sv -----
// Shared constants, types and controller commands for the K-way merge block
package kwm_pkg;

    localparam int LANES      = 8;
    localparam int LANE_DEPTH = 64;

    localparam int LANE_W    = 3;
    localparam int VALUE_W   = 32;
    localparam int ACT_W     = 4;
    localparam int ACT_RESET = 8;

    localparam int LANE_IDX_W = $clog2(LANES);
    localparam int PTR_W      = $clog2(LANE_DEPTH);
    localparam int FILL_W     = $clog2(LANE_DEPTH + 1);
    localparam int ADDR_W     = $clog2(LANES * LANE_DEPTH);
    localparam int CMP_W      = ((LANE_IDX_W > ACT_W) ? LANE_IDX_W : ACT_W) + 1;
    localparam int CHK_W      = ((LANE_IDX_W > LANE_W) ? LANE_IDX_W : LANE_W) + 1;

    typedef enum logic [1:0] {
        ST_APPENDED = 2'd0,
        ST_POPPED   = 2'd1,
        ST_DROPPED  = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef struct packed {
        logic                  capture;
        logic                  append;
        logic                  scan_first;
        logic                  scan_issue;
        logic [LANE_IDX_W-1:0] scan_idx;
        logic                  finish;
    } ctrl_cmd_t;

endpackage

// ----- sv/kwm_ctrl.sv -----
// Controller state machine: sequences append, head scan and pop finish
module kwm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               cmd,
    output logic               busy,
    output kwm_pkg::ctrl_cmd_t ctrl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_APPEND,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } state_t;

    localparam logic [kwm_pkg::LANE_IDX_W-1:0] LAST_IDX =
        kwm_pkg::LANE_IDX_W'(kwm_pkg::LANES - 1);

    state_t                          state_reg, state_next;
    logic                            busy_reg, busy_next;
    logic [kwm_pkg::LANE_IDX_W-1:0]  idx_reg, idx_next;

    always_comb
    begin
        state_next      = state_reg;
        busy_next       = busy_reg;
        idx_next        = idx_reg;
        ctrl            = '0;
        ctrl.scan_idx   = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl.capture = 1'b1;
                    busy_next    = 1'b1;
                    idx_next     = '0;
                    state_next   = cmd ? S_SCAN : S_APPEND;
                end
            end
            S_APPEND:
            begin
                ctrl.append = 1'b1;
                busy_next   = 1'b0;
                state_next  = S_IDLE;
            end
            S_SCAN:
            begin
                ctrl.scan_issue = 1'b1;
                ctrl.scan_first = (idx_reg == '0);
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = S_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                ctrl.finish = 1'b1;
                busy_next   = 1'b0;
                state_next  = S_IDLE;
            end
            default:
            begin
                busy_next  = 1'b0;
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            idx_reg   <= idx_next;
        end
    end

    assign busy = busy_reg;

endmodule

// ----- sv/kwm_dp.sv -----
// Datapath: lane memory, per-lane pointers, head compare and result registers
`include "assert_macros.svh"

module kwm_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  kwm_pkg::ctrl_cmd_t                  ctrl,
    input  logic [kwm_pkg::LANE_W-1:0]          lane,
    input  logic signed [kwm_pkg::VALUE_W-1:0]  value,
    input  logic                                active_lanes_we,
    input  logic [kwm_pkg::ACT_W-1:0]           active_lanes_wdata,
    output logic                                done,
    output logic [1:0]                          status,
    output logic signed [kwm_pkg::VALUE_W-1:0]  out_value,
    output logic [kwm_pkg::LANE_W-1:0]          source_lane
);

    localparam int MEM_WORDS = kwm_pkg::LANES * kwm_pkg::LANE_DEPTH;

    logic signed [kwm_pkg::VALUE_W-1:0] mem [MEM_WORDS];

    logic [kwm_pkg::PTR_W-1:0]      rd_ptr_reg [kwm_pkg::LANES];
    logic [kwm_pkg::PTR_W-1:0]      wr_ptr_reg [kwm_pkg::LANES];
    logic [kwm_pkg::FILL_W-1:0]     fill_reg   [kwm_pkg::LANES];
    logic [kwm_pkg::ACT_W-1:0]      active_lanes_reg;

    logic [kwm_pkg::LANE_W-1:0]          lane_reg;
    logic signed [kwm_pkg::VALUE_W-1:0]  value_reg;

    logic signed [kwm_pkg::VALUE_W-1:0]  mem_q_reg;
    logic                                rd_valid_reg, rd_valid_next;
    logic [kwm_pkg::LANE_IDX_W-1:0]      rd_lane_reg;

    logic                                found_reg;
    logic signed [kwm_pkg::VALUE_W-1:0]  best_val_reg;
    logic [kwm_pkg::LANE_IDX_W-1:0]      best_lane_reg;

    logic                                done_reg;
    kwm_pkg::status_t                    status_reg, status_next;
    logic signed [kwm_pkg::VALUE_W-1:0]  out_value_reg, out_value_next;
    logic [kwm_pkg::LANE_W-1:0]          source_lane_reg, source_lane_next;

    logic [kwm_pkg::LANE_IDX_W-1:0]  app_idx;
    logic                            app_ok;
    logic [kwm_pkg::ADDR_W-1:0]      wr_addr;
    logic [kwm_pkg::ADDR_W-1:0]      rd_addr;
    logic                            better;

    function automatic logic [kwm_pkg::PTR_W-1:0] ptr_inc(
        input logic [kwm_pkg::PTR_W-1:0] p
    );
        ptr_inc = (p == kwm_pkg::PTR_W'(kwm_pkg::LANE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign app_idx = kwm_pkg::LANE_IDX_W'(lane_reg);
    assign app_ok  = (kwm_pkg::CHK_W'(lane_reg) < kwm_pkg::CHK_W'(kwm_pkg::LANES))
                  && (fill_reg[app_idx] < kwm_pkg::FILL_W'(kwm_pkg::LANE_DEPTH));
    assign wr_addr = kwm_pkg::ADDR_W'(app_idx) * kwm_pkg::ADDR_W'(kwm_pkg::LANE_DEPTH)
                   + kwm_pkg::ADDR_W'(wr_ptr_reg[app_idx]);
    assign rd_addr = kwm_pkg::ADDR_W'(ctrl.scan_idx) * kwm_pkg::ADDR_W'(kwm_pkg::LANE_DEPTH)
                   + kwm_pkg::ADDR_W'(rd_ptr_reg[ctrl.scan_idx]);

    assign rd_valid_next = ctrl.scan_issue
        && (kwm_pkg::CMP_W'(ctrl.scan_idx) < kwm_pkg::CMP_W'(active_lanes_reg))
        && (fill_reg[ctrl.scan_idx] != '0);

    assign better = rd_valid_reg && (!found_reg || (mem_q_reg <= best_val_reg));

    always_comb
    begin
        status_next      = status_reg;
        out_value_next   = out_value_reg;
        source_lane_next = source_lane_reg;
        if (ctrl.append)
        begin
            status_next      = app_ok ? kwm_pkg::ST_APPENDED : kwm_pkg::ST_DROPPED;
            out_value_next   = '0;
            source_lane_next = '0;
        end
        else if (ctrl.finish)
        begin
            if (found_reg)
            begin
                status_next      = kwm_pkg::ST_POPPED;
                out_value_next   = best_val_reg;
                source_lane_next = kwm_pkg::LANE_W'(best_lane_reg);
            end
            else
            begin
                status_next      = kwm_pkg::ST_EMPTY;
                out_value_next   = '0;
                source_lane_next = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.append && app_ok)
        begin
            mem[wr_addr] <= value_reg;
        end
        if (ctrl.scan_issue)
        begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            lane_reg  <= lane;
            value_reg <= value;
        end
        rd_lane_reg <= ctrl.scan_idx;
        if (better)
        begin
            best_val_reg  <= mem_q_reg;
            best_lane_reg <= rd_lane_reg;
        end
        status_reg      <= status_next;
        out_value_reg   <= out_value_next;
        source_lane_reg <= source_lane_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < kwm_pkg::LANES; i++)
            begin
                rd_ptr_reg[i] <= '0;
                wr_ptr_reg[i] <= '0;
                fill_reg[i]   <= '0;
            end
            active_lanes_reg <= kwm_pkg::ACT_W'(kwm_pkg::ACT_RESET);
            rd_valid_reg     <= 1'b0;
            found_reg        <= 1'b0;
            done_reg         <= 1'b0;
        end
        else
        begin
            if (active_lanes_we)
            begin
                active_lanes_reg <= active_lanes_wdata;
            end
            rd_valid_reg <= rd_valid_next;
            if (ctrl.scan_first)
            begin
                found_reg <= 1'b0;
            end
            else if (better)
            begin
                found_reg <= 1'b1;
            end
            if (ctrl.append && app_ok)
            begin
                wr_ptr_reg[app_idx] <= ptr_inc(wr_ptr_reg[app_idx]);
                fill_reg[app_idx]   <= fill_reg[app_idx] + 1'b1;
            end
            if (ctrl.finish && found_reg)
            begin
                rd_ptr_reg[best_lane_reg] <= ptr_inc(rd_ptr_reg[best_lane_reg]);
                fill_reg[best_lane_reg]   <= fill_reg[best_lane_reg] - 1'b1;
            end
            done_reg <= ctrl.append || ctrl.finish;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign out_value   = out_value_reg;
    assign source_lane = source_lane_reg;

    `KWM_ASSERT_IMP(a_zero_unless_pop, clk, rst_n,
        done_reg && (status_reg != kwm_pkg::ST_POPPED),
        (out_value_reg == '0) && (source_lane_reg == '0))
    `KWM_ASSERT_NEXT(a_append_result, clk, rst_n, ctrl.append, done_reg)
    `KWM_ASSERT_NEXT(a_finish_result, clk, rst_n, ctrl.finish, done_reg)
    `KWM_ASSERT_NEXT(a_single_strobe, clk, rst_n, done_reg, !done_reg)

endmodule

// ----- sv/k_way_merge_select.sv -----
// Top level of the K-way merge block: controller plus datapath
//
//   channel   signals                               transfer when
//   input     start, busy, cmd, lane, value         start high and busy low
//   result    done, status, out_value, source_lane  done high (one cycle)
//   config    active_lanes_we, active_lanes_wdata   active_lanes_we high
//
// An append is accepted, then performs one lane-memory write.
// A pop reads the lane heads one lane per cycle through the single read port
// of the lane memory and compares them in turn.
// Reset clears all lane pointers and fill counts; lane memory is not cleared.
// The result strobe cannot be stalled; busy holds off the next input.
module k_way_merge_select (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                cmd,
    input  logic [kwm_pkg::LANE_W-1:0]          lane,
    input  logic signed [kwm_pkg::VALUE_W-1:0]  value,
    input  logic                                active_lanes_we,
    input  logic [kwm_pkg::ACT_W-1:0]           active_lanes_wdata,
    output logic                                done,
    output logic [1:0]                          status,
    output logic signed [kwm_pkg::VALUE_W-1:0]  out_value,
    output logic [kwm_pkg::LANE_W-1:0]          source_lane
);

    kwm_pkg::ctrl_cmd_t ctrl;

    kwm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .ctrl  (ctrl)
    );

    kwm_dp u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .ctrl               (ctrl),
        .lane               (lane),
        .value              (value),
        .active_lanes_we    (active_lanes_we),
        .active_lanes_wdata (active_lanes_wdata),
        .done               (done),
        .status             (status),
        .out_value          (out_value),
        .source_lane        (source_lane)
    );

endmodule
